>>> rtl/nearly_sorted_search_defines.svh
// ---------------------------------------------------------------------------
// nearly_sorted_search assertion macros
// Shared concurrent assertion forms for the search block's checker.
// ---------------------------------------------------------------------------
`ifndef NEARLY_SORTED_SEARCH_DEFINES_SVH
`define NEARLY_SORTED_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nss_pkg.sv
// ---------------------------------------------------------------------------
// nss_pkg
// Types and constants shared by the nearly sorted search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nss_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int DATA_W           = 32;
   localparam int INDEX_W          = 10;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE_MID,
      ST_TEST_MID,
      ST_TEST_NEXT,
      ST_TEST_PREV,
      ST_DONE
   } state_type;

   // which of the three probe positions around the midpoint
   typedef enum logic [1:0] {
      SEL_MID,
      SEL_NEXT,
      SEL_PREV
   } probe_sel_type;

   typedef struct packed {
      logic          load;
      logic          append;
      logic          issue_mid;
      probe_sel_type addr_sel;
      logic          latch_gt;
      logic          set_hit;
      probe_sel_type hit_sel;
      logic          narrow;
      logic          publish;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic rd_eq;
      logic next_ok;
      logic prev_ok;
   } sts_type;

endpackage

>>> rtl/nss_if.sv
// ---------------------------------------------------------------------------
// nss_if
// Valid/ready channels for requests and responses of the search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nss_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic                                new_array;
   logic signed [nss_pkg::DATA_W-1:0]   elem_value;
   logic signed [nss_pkg::DATA_W-1:0]   target;

   modport source (output valid, req_type, new_array, elem_value, target, input ready);
   modport sink   (input valid, req_type, new_array, elem_value, target, output ready);
endinterface

interface nss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [nss_pkg::INDEX_W-1:0]  found_index;

   modport source (output valid, found, found_index, input ready);
   modport sink   (input valid, found, found_index, output ready);
endinterface

>>> rtl/nss_datapath.sv
// ---------------------------------------------------------------------------
// nss_datapath
// Element memory, element count, search range registers and response data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nss_datapath #(
   parameter int MAX_ELEMENTS = nss_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nss_pkg::cmd_type                    cmd,
   output nss_pkg::sts_type                    sts,
   input  logic                                new_array,
   input  logic signed [nss_pkg::DATA_W-1:0]   elem_value,
   input  logic signed [nss_pkg::DATA_W-1:0]   target,
   output logic                                found,
   output logic [nss_pkg::INDEX_W-1:0]         found_index
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int SW = CW + 2;
   localparam logic signed [SW-1:0] ONE = SW'(1);
   localparam logic signed [SW-1:0] TWO = SW'(2);

   logic signed [nss_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
   logic signed [nss_pkg::DATA_W-1:0] rd_ff;
   logic signed [nss_pkg::DATA_W-1:0] target_ff;

   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        base;
   logic                 room;
   logic                 wr_en;
   logic signed [SW-1:0] count_ext;
   logic signed [SW-1:0] start_ff, end_ff, mid_ff;
   logic signed [SW-1:0] mid_calc, next_idx, prev_idx;
   logic [AW-1:0]        rd_addr, hit_idx, where_ff;
   logic                 gt_ff, hit_ff;
   logic                 found_ff;
   logic [nss_pkg::INDEX_W-1:0] index_ff;

   // append position: restart at zero for a new array
   assign base      = new_array ? '0 : count_ff;
   assign room      = base < CW'(MAX_ELEMENTS);
   assign wr_en     = cmd.append && room;
   assign count_in  = cmd.append ? (room ? base + CW'(1) : base) : count_ff;
   assign count_ext = signed'(SW'(count_ff));

   assign mid_calc = start_ff + ((end_ff - start_ff) >>> 1);
   assign next_idx = mid_ff + ONE;
   assign prev_idx = mid_ff - ONE;

   always_comb begin
      unique case (cmd.addr_sel)
         nss_pkg::SEL_MID:  rd_addr = mid_calc[AW-1:0];
         nss_pkg::SEL_NEXT: rd_addr = next_idx[AW-1:0];
         nss_pkg::SEL_PREV: rd_addr = prev_idx[AW-1:0];
         default:           rd_addr = mid_calc[AW-1:0];
      endcase
   end

   always_comb begin
      unique case (cmd.hit_sel)
         nss_pkg::SEL_MID:  hit_idx = mid_ff[AW-1:0];
         nss_pkg::SEL_NEXT: hit_idx = next_idx[AW-1:0];
         nss_pkg::SEL_PREV: hit_idx = prev_idx[AW-1:0];
         default:           hit_idx = mid_ff[AW-1:0];
      endcase
   end

   // neighbor probes count only inside the stored array
   assign sts.range_ok = start_ff <= end_ff;
   assign sts.rd_eq    = rd_ff == target_ff;
   assign sts.next_ok  = next_idx < count_ext;
   assign sts.prev_ok  = mid_ff != '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[base[AW-1:0]] <= elem_value;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff  <= '0;
         end_ff    <= count_ext - ONE;
         target_ff <= target;
         hit_ff    <= 1'b0;
         where_ff  <= '0;
      end
      if (cmd.issue_mid) begin
         mid_ff <= mid_calc;
      end
      if (cmd.latch_gt) begin
         gt_ff <= rd_ff > target_ff;
      end
      if (cmd.narrow) begin
         if (gt_ff) begin
            end_ff <= mid_ff - TWO;
         end else begin
            start_ff <= mid_ff + TWO;
         end
      end
      if (cmd.set_hit) begin
         hit_ff   <= 1'b1;
         where_ff <= hit_idx;
      end
      if (cmd.publish) begin
         found_ff <= hit_ff;
         index_ff <= nss_pkg::INDEX_W'(where_ff);
      end
   end

   assign found       = found_ff;
   assign found_index = index_ff;

endmodule

>>> rtl/nss_controller.sv
// ---------------------------------------------------------------------------
// nss_controller
// Sequencer for appends and the probe-and-narrow search loop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nss_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  nss_pkg::sts_type  sts,
   output nss_pkg::cmd_type  cmd
);

   nss_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               slot_free;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nss_pkg::ST_IDLE: begin
            if (accept && req_type == nss_pkg::REQ_SEARCH) begin
               state_in = nss_pkg::ST_PROBE_MID;
            end
         end
         nss_pkg::ST_PROBE_MID: begin
            state_in = sts.range_ok ? nss_pkg::ST_TEST_MID : nss_pkg::ST_DONE;
         end
         nss_pkg::ST_TEST_MID: begin
            state_in = sts.rd_eq ? nss_pkg::ST_DONE : nss_pkg::ST_TEST_NEXT;
         end
         nss_pkg::ST_TEST_NEXT: begin
            state_in = (sts.next_ok && sts.rd_eq) ? nss_pkg::ST_DONE : nss_pkg::ST_TEST_PREV;
         end
         nss_pkg::ST_TEST_PREV: begin
            state_in = (sts.prev_ok && sts.rd_eq) ? nss_pkg::ST_DONE : nss_pkg::ST_PROBE_MID;
         end
         nss_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = nss_pkg::ST_IDLE;
            end
         end
         default: state_in = nss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.addr_sel = nss_pkg::SEL_MID;
      cmd.hit_sel  = nss_pkg::SEL_MID;
      unique case (state_ff)
         nss_pkg::ST_IDLE: begin
            // ready is always high here, so valid alone marks a taken request
            req_ready  = 1'b1;
            cmd.load   = req_valid && req_type == nss_pkg::REQ_SEARCH;
            cmd.append = req_valid && req_type == nss_pkg::REQ_APPEND;
         end
         nss_pkg::ST_PROBE_MID: begin
            cmd.issue_mid = sts.range_ok;
         end
         nss_pkg::ST_TEST_MID: begin
            // read data is the midpoint element; fetch its upper neighbor
            cmd.latch_gt = 1'b1;
            cmd.addr_sel = nss_pkg::SEL_NEXT;
            cmd.set_hit  = sts.rd_eq;
         end
         nss_pkg::ST_TEST_NEXT: begin
            cmd.addr_sel = nss_pkg::SEL_PREV;
            cmd.hit_sel  = nss_pkg::SEL_NEXT;
            cmd.set_hit  = sts.next_ok && sts.rd_eq;
         end
         nss_pkg::ST_TEST_PREV: begin
            cmd.hit_sel = nss_pkg::SEL_PREV;
            cmd.set_hit = sts.prev_ok && sts.rd_eq;
            cmd.narrow  = !(sts.prev_ok && sts.rd_eq);
         end
         nss_pkg::ST_DONE: begin
            cmd.publish = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // hold the response until taken
   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/nearly_sorted_search.sv
// ---------------------------------------------------------------------------
// nearly_sorted_search: append store and probe-and-narrow search
// Append requests give no response; the next request may follow at once.
// A search runs halving steps (midpoint and both neighbours read on one memory port),
// at most 9 steps for 1024 elements, and then waits until the previous response is
// taken; one request at a time.
// Synchronous reset clears the count and the control state; the memory is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearly_sorted_search #(
   parameter int MAX_ELEMENTS = nss_pkg::MAX_ELEMENTS_DEF
) (
   input logic      clock,
   input logic      reset,
   nss_req_if.sink   req_ch,
   nss_rsp_if.source rsp_ch
);

   nss_pkg::cmd_type cmd;
   nss_pkg::sts_type sts;

   nss_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nss_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .new_array   (req_ch.new_array),
      .elem_value  (req_ch.elem_value),
      .target      (req_ch.target),
      .found       (rsp_ch.found),
      .found_index (rsp_ch.found_index)
   );

endmodule

>>> rtl/nss_checker.sv
// ---------------------------------------------------------------------------
// nss_checker
// Port-level checks for the nearly sorted search block, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearly_sorted_search_defines.svh"

module nss_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_type,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [nss_pkg::INDEX_W-1:0] rsp_found_index
);

   `NSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_found_index), "response changed while stalled")
   `NSS_ASSERT_IMPLY(a_miss_index, clock, reset, rsp_valid && !rsp_found, rsp_found_index == '0, "miss with nonzero index")
   `NSS_ASSERT_NEXT(a_search_busy, clock, reset, req_valid && req_ready && req_type == nss_pkg::REQ_SEARCH, !req_ready, "request taken during a search")
   `NSS_ASSERT_NEXT(a_append_silent, clock, reset, req_valid && req_ready && req_type == nss_pkg::REQ_APPEND && !rsp_valid, !rsp_valid, "append produced a response")

endmodule

bind nearly_sorted_search nss_checker u_nss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_type        (req_ch.req_type),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found       (rsp_ch.found),
   .rsp_found_index (rsp_ch.found_index)
);
